FILE: rtl/cpu6502_execute_unit_assert.svh
// Assertion macros for the execute unit.
// Include with the bare file name; needs i_clk and i_rst_n in scope.
`ifndef CPU6502_EXECUTE_UNIT_ASSERT_SVH
`define CPU6502_EXECUTE_UNIT_ASSERT_SVH
`define CEU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CEU_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

FILE: rtl/ceu_pkg.sv
// Package for the execute unit: opcode codes, flag positions, reset values.
// No dependencies.
package ceu_pkg;
    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
        OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
        OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
        OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
        OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
        OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
        OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
        OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
        OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
        OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
        OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
        OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
        OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
        OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55,
        OP_WAI = 6'd56, OP_IRQ = 6'd57, OP_NMI = 6'd58
    } t_op;
    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_B = 4;
    localparam int FL_U = 5;
    localparam int FL_V = 6;
    localparam int FL_N = 7;
    localparam logic [7:0] SP_RESET = 8'hFD;
    localparam logic [7:0] P_RESET  = 8'h24;
    localparam logic [7:0] STACK_PAGE = 8'h01;
    typedef struct packed {
        logic [5:0]  op;
        logic [7:0]  operand;
        logic [15:0] target_address;
        logic        acc_mode;
        logic [15:0] next_pc;
        logic [7:0]  pulled_first;
        logic [7:0]  pulled_second;
        logic [7:0]  pulled_third;
        logic [15:0] vector;
    } t_in;
    typedef struct packed {
        logic        write_en;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  sp_out;
        logic [7:0]  status_out;
        logic [15:0] pc_out;
        logic        invalid_op;
        logic        waiting;
        logic        last;
    } t_out;
endpackage

FILE: rtl/ceu_if.sv
// Valid/ready channels, each carrying one payload type.
// Uses ceu_pkg for the payload types.
interface ceu_in_if import ceu_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ceu_out_if import ceu_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/cpu6502_execute_unit.sv
// Execute unit top level: architectural registers, instruction execute, result queue.
// Depends on ceu_pkg, ceu_in_if, ceu_out_if and cpu6502_execute_unit_assert.svh.
// An instruction is taken when valid and ready are both high; the register file
// updates at that edge. Its results (one, or one per memory write, up to three for
// interrupts) leave a four-entry result FIFO, one per cycle while the output is ready.
// Input ready is held low unless three free entries exist, so with the output ready a
// single-write instruction sustains one per cycle; a three-push interrupt stalls input.
`include "cpu6502_execute_unit_assert.svh"
module cpu6502_execute_unit import ceu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ceu_in_if.sink    i_in,
    ceu_out_if.source o_out
);
    logic [7:0]  r_a, r_x, r_y, r_sp, r_p;
    logic [15:0] r_pc;
    logic        r_wait, r_inv;
    logic [7:0]  n_a, n_x, n_y, n_sp, n_p;
    logic [15:0] n_pc;
    logic        n_wait, n_inv;
    logic [1:0]  n_cnt;
    logic [15:0] wa [3];
    logic [7:0]  wd [3];

    t_out        r_q [4];
    logic [1:0]  r_rd, r_wr;
    logic [2:0]  r_lvl;
    logic        acc, pop;
    t_in         d;

    assign d = i_in.data;
    assign i_in.ready = (r_lvl <= 3'd1);
    assign acc = i_in.valid && i_in.ready;
    assign o_out.valid = (r_lvl != 3'd0);
    assign o_out.data = r_q[r_rd];
    assign pop = o_out.valid && o_out.ready;

    function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q = p;
        q[FL_N] = v[7];
        q[FL_Z] = (v == 8'd0);
        return q;
    endfunction

    always_comb begin
        logic [8:0]  s;
        logic [7:0]  m2, v, r, t;
        logic [15:0] ret;
        logic [7:0]  pst;
        logic        take, irq;
        n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp; n_p = r_p;
        n_pc = r_pc; n_wait = r_wait; n_inv = r_inv; n_cnt = 2'd0;
        take = 1'b0;
        m2 = (d.op == OP_SBC) ? ~d.operand : d.operand;
        s = {1'b0, r_a} + {1'b0, m2} + {8'd0, r_p[FL_C]};
        v = d.acc_mode ? r_a : d.operand;
        r = 8'd0;
        t = 8'd0;
        ret = d.next_pc;
        pst = r_p | 8'h30;
        irq = (d.op == OP_IRQ) || (d.op == OP_NMI);
        for (int k = 0; k < 3; k++) begin
            wa[k] = 16'd0;
            wd[k] = 8'd0;
        end
        if (irq || d.op == OP_BRK) begin
            if (d.op == OP_BRK) ret = d.next_pc + 16'd1;
            else pst = (r_p & 8'hEF) | 8'h20;
        end
        if (irq) begin
            n_wait = 1'b0;
            if (d.op == OP_NMI || !r_p[FL_I]) begin
                n_cnt = 2'd3;
                n_sp = r_sp - 8'd3;
                n_p[FL_I] = 1'b1;
                n_pc = d.vector;
            end
        end else if (!r_wait) begin
            n_pc = d.next_pc;
            unique case (d.op)
                OP_ADC, OP_SBC: begin
                    n_p[FL_V] = (r_a[7] ^ s[7]) & (m2[7] ^ s[7]);
                    n_p[FL_C] = s[8];
                    n_a = s[7:0];
                    n_p = nz(n_p, s[7:0]);
                end
                OP_AND: begin n_a = r_a & d.operand; n_p = nz(n_p, n_a); end
                OP_EOR: begin n_a = r_a ^ d.operand; n_p = nz(n_p, n_a); end
                OP_ORA: begin n_a = r_a | d.operand; n_p = nz(n_p, n_a); end
                OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                    if (d.op == OP_ASL || d.op == OP_ROL) begin
                        r = {v[6:0], (d.op == OP_ROL) ? r_p[FL_C] : 1'b0};
                        n_p[FL_C] = v[7];
                    end else begin
                        r = {(d.op == OP_ROR) ? r_p[FL_C] : 1'b0, v[7:1]};
                        n_p[FL_C] = v[0];
                    end
                    n_p = nz(n_p, r);
                    if (d.op == OP_LSR) n_p[FL_N] = 1'b0;
                    if (d.acc_mode) n_a = r;
                    else begin n_cnt = 2'd1; wa[0] = d.target_address; wd[0] = r; end
                end
                OP_BCC: take = !r_p[FL_C];
                OP_BCS: take = r_p[FL_C];
                OP_BEQ: take = r_p[FL_Z];
                OP_BNE: take = !r_p[FL_Z];
                OP_BMI: take = r_p[FL_N];
                OP_BPL: take = !r_p[FL_N];
                OP_BVC: take = !r_p[FL_V];
                OP_BVS: take = r_p[FL_V];
                OP_BIT: begin
                    n_p[FL_Z] = ((r_a & d.operand) == 8'd0);
                    n_p[FL_N] = d.operand[7];
                    n_p[FL_V] = d.operand[6];
                end
                OP_BRK: begin
                    n_cnt = 2'd3; n_sp = r_sp - 8'd3;
                    n_p[FL_I] = 1'b1; n_pc = d.vector;
                end
                OP_CLC: n_p[FL_C] = 1'b0;
                OP_CLD: n_p[FL_D] = 1'b0;
                OP_CLI: n_p[FL_I] = 1'b0;
                OP_CLV: n_p[FL_V] = 1'b0;
                OP_SEC: n_p[FL_C] = 1'b1;
                OP_SED: n_p[FL_D] = 1'b1;
                OP_SEI: n_p[FL_I] = 1'b1;
                OP_CMP, OP_CPX, OP_CPY: begin
                    t = (d.op == OP_CMP) ? r_a : ((d.op == OP_CPX) ? r_x : r_y);
                    n_p[FL_C] = (t >= d.operand);
                    n_p = nz(n_p, t - d.operand);
                end
                OP_DEC, OP_INC: begin
                    r = (d.op == OP_DEC) ? d.operand - 8'd1 : d.operand + 8'd1;
                    n_p = nz(n_p, r);
                    n_cnt = 2'd1; wa[0] = d.target_address; wd[0] = r;
                end
                OP_DEX: begin n_x = r_x - 8'd1; n_p = nz(n_p, n_x); end
                OP_DEY: begin n_y = r_y - 8'd1; n_p = nz(n_p, n_y); end
                OP_INX: begin n_x = r_x + 8'd1; n_p = nz(n_p, n_x); end
                OP_INY: begin n_y = r_y + 8'd1; n_p = nz(n_p, n_y); end
                OP_JMP: n_pc = d.target_address;
                OP_JSR: begin
                    ret = d.next_pc - 16'd1;
                    n_cnt = 2'd2; n_sp = r_sp - 8'd2; n_pc = d.target_address;
                end
                OP_LDA: begin n_a = d.operand; n_p = nz(n_p, n_a); end
                OP_LDX: begin n_x = d.operand; n_p = nz(n_p, n_x); end
                OP_LDY: begin n_y = d.operand; n_p = nz(n_p, n_y); end
                OP_NOP: ;
                OP_PHA: begin
                    n_cnt = 2'd1; n_sp = r_sp - 8'd1;
                    wa[0] = {STACK_PAGE, r_sp}; wd[0] = r_a;
                end
                OP_PHP: begin
                    n_cnt = 2'd1; n_sp = r_sp - 8'd1;
                    wa[0] = {STACK_PAGE, r_sp}; wd[0] = r_p | 8'h30;
                end
                OP_PLA: begin
                    n_sp = r_sp + 8'd1; n_a = d.pulled_first; n_p = nz(n_p, n_a);
                end
                OP_PLP: begin
                    n_sp = r_sp + 8'd1; n_p = (d.pulled_first & 8'hCF) | 8'h20;
                end
                OP_RTI: begin
                    n_sp = r_sp + 8'd3; n_p = (d.pulled_first & 8'hCF) | 8'h20;
                    n_pc = {d.pulled_third, d.pulled_second};
                end
                OP_RTS: begin
                    n_sp = r_sp + 8'd2;
                    n_pc = {d.pulled_second, d.pulled_first} + 16'd1;
                end
                OP_STA: begin n_cnt = 2'd1; wa[0] = d.target_address; wd[0] = r_a; end
                OP_STX: begin n_cnt = 2'd1; wa[0] = d.target_address; wd[0] = r_x; end
                OP_STY: begin n_cnt = 2'd1; wa[0] = d.target_address; wd[0] = r_y; end
                OP_TAX: begin n_x = r_a; n_p = nz(n_p, n_x); end
                OP_TAY: begin n_y = r_a; n_p = nz(n_p, n_y); end
                OP_TSX: begin n_x = r_sp; n_p = nz(n_p, n_x); end
                OP_TXA: begin n_a = r_x; n_p = nz(n_p, n_a); end
                OP_TXS: n_sp = r_x;
                OP_TYA: begin n_a = r_y; n_p = nz(n_p, n_a); end
                OP_WAI: n_wait = 1'b1;
                default: n_inv = 1'b1;
            endcase
            if (take) n_pc = d.target_address;
        end
        if (n_cnt >= 2'd2) begin
            wa[0] = {STACK_PAGE, r_sp};        wd[0] = ret[15:8];
            wa[1] = {STACK_PAGE, r_sp - 8'd1}; wd[1] = ret[7:0];
            wa[2] = {STACK_PAGE, r_sp - 8'd2}; wd[2] = pst;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [2:0] n_push;
        n_push = 3'd0;
        if (!i_rst_n) begin
            r_a <= 8'd0; r_x <= 8'd0; r_y <= 8'd0;
            r_sp <= SP_RESET; r_p <= P_RESET; r_pc <= 16'd0;
            r_wait <= 1'b0; r_inv <= 1'b0;
            r_rd <= 2'd0; r_wr <= 2'd0; r_lvl <= 3'd0;
        end else begin
            if (acc) begin
                r_a <= n_a; r_x <= n_x; r_y <= n_y; r_sp <= n_sp; r_p <= n_p;
                r_pc <= n_pc; r_wait <= n_wait; r_inv <= n_inv;
                n_push = (n_cnt == 2'd0) ? 3'd1 : {1'b0, n_cnt};
                for (int k = 0; k < 3; k++) begin
                    if (3'(k) < n_push) begin
                        r_q[r_wr + 2'(k)] <= '{
                            write_en: (n_cnt != 2'd0), write_address: wa[k],
                            write_data: wd[k], acc_out: n_a, x_out: n_x, y_out: n_y,
                            sp_out: n_sp, status_out: n_p, pc_out: n_pc,
                            invalid_op: n_inv, waiting: n_wait,
                            last: (3'(k) + 3'd1 == n_push)};
                    end
                end
            end
            r_wr <= r_wr + n_push[1:0];
            if (pop) r_rd <= r_rd + 2'd1;
            r_lvl <= r_lvl + n_push - {2'd0, pop};
        end
    end

    `CEU_ASSERT(a_lvl_bound, r_lvl <= 3'd4, "result queue overflow")
    `CEU_ASSERT(a_flag_u, r_p[FL_U] && !r_p[FL_B], "status bits 4/5 wrong")
    `CEU_ASSERT(a_ready_room, i_in.ready |-> r_lvl <= 3'd1, "ready without room")
    `CEU_ASSERT_RST(a_reset_empty, !i_rst_n |=> r_lvl == 3'd0, "queue not empty after reset")
endmodule

FILE: tb/cpu6502_execute_unit_checker.sv
// Checker for the execute unit: predicts results of each input transfer and compares them.
// Depends on ceu_pkg and the ceu_in_if / ceu_out_if channel interfaces.
`timescale 1ns / 100ps
module cpu6502_execute_unit_checker import ceu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ceu_in_if  i_in,
    ceu_out_if i_out,
    output int o_errors,
    output int o_pending
);
    logic [7:0]  reg_a, reg_x, reg_y, reg_sp, reg_p;
    logic [15:0] reg_pc;
    logic        wait_st, bad_st;
    t_out        expected_q[$];
    logic [15:0] wr_addr[3];
    logic [7:0]  wr_data[3];
    int          wr_n;

    assign o_pending = expected_q.size();

    function automatic logic [7:0] set_nz(logic [7:0] v);
        reg_p[FL_N] = v[7];
        reg_p[FL_Z] = (v == 8'h00);
        return v;
    endfunction

    task automatic push_byte(logic [7:0] v);
        wr_addr[wr_n] = {STACK_PAGE, reg_sp};
        wr_data[wr_n] = v;
        wr_n++;
        reg_sp = reg_sp - 8'd1;
    endtask

    task automatic add_carry(logic [7:0] m);
        logic [8:0] s;
        s = {1'b0, reg_a} + {1'b0, m} + {8'd0, reg_p[FL_C]};
        reg_p[FL_V] = (reg_a[7] ^ s[7]) & (m[7] ^ s[7]);
        reg_p[FL_C] = s[8];
        reg_a = set_nz(s[7:0]);
    endtask

    task automatic enter_irq(logic [15:0] ret, logic [7:0] st, logic [15:0] vec);
        push_byte(ret[15:8]);
        push_byte(ret[7:0]);
        push_byte(st);
        reg_p[FL_I] = 1'b1;
        reg_pc = vec;
    endtask

    task automatic load_status(logic [7:0] v);
        reg_p = v;
        reg_p[FL_B] = 1'b0;
        reg_p[FL_U] = 1'b1;
    endtask

    task automatic predict_instr(t_in d);
        logic       take, cin;
        logic [7:0] v, r, m;
        t_out       e;
        int         n;
        take = 1'b0;
        wr_n = 0;
        m = d.operand;
        if (d.op == OP_IRQ || d.op == OP_NMI) begin
            wait_st = 1'b0;
            if (d.op == OP_NMI || !reg_p[FL_I]) begin
                v = reg_p;
                v[FL_B] = 1'b0;
                v[FL_U] = 1'b1;
                enter_irq(d.next_pc, v, d.vector);
            end
        end else if (!wait_st) begin
            reg_pc = d.next_pc;
            case (d.op)
                OP_ADC: add_carry(m);
                OP_AND: reg_a = set_nz(reg_a & m);
                OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                    v = d.acc_mode ? reg_a : m;
                    cin = reg_p[FL_C];
                    case (d.op)
                        OP_ASL:  begin r = v << 1; reg_p[FL_C] = v[7]; end
                        OP_LSR:  begin r = v >> 1; reg_p[FL_C] = v[0]; end
                        OP_ROL:  begin r = {v[6:0], cin}; reg_p[FL_C] = v[7]; end
                        default: begin r = {cin, v[7:1]}; reg_p[FL_C] = v[0]; end
                    endcase
                    r = set_nz(r);
                    if (d.acc_mode) reg_a = r;
                    else begin
                        wr_addr[0] = d.target_address;
                        wr_data[0] = r;
                        wr_n = 1;
                    end
                    if (d.op == OP_LSR) reg_p[FL_N] = 1'b0;
                end
                OP_BCC: take = !reg_p[FL_C];
                OP_BCS: take = reg_p[FL_C];
                OP_BEQ: take = reg_p[FL_Z];
                OP_BMI: take = reg_p[FL_N];
                OP_BNE: take = !reg_p[FL_Z];
                OP_BPL: take = !reg_p[FL_N];
                OP_BVC: take = !reg_p[FL_V];
                OP_BVS: take = reg_p[FL_V];
                OP_BIT: begin
                    reg_p[FL_Z] = ((reg_a & m) == 8'h00);
                    reg_p[FL_N] = m[7];
                    reg_p[FL_V] = m[6];
                end
                OP_BRK: enter_irq(d.next_pc + 16'd1, reg_p | 8'h30, d.vector);
                OP_CLC: reg_p[FL_C] = 1'b0;
                OP_CLD: reg_p[FL_D] = 1'b0;
                OP_CLI: reg_p[FL_I] = 1'b0;
                OP_CLV: reg_p[FL_V] = 1'b0;
                OP_CMP, OP_CPX, OP_CPY: begin
                    v = (d.op == OP_CMP) ? reg_a : (d.op == OP_CPX) ? reg_x : reg_y;
                    reg_p[FL_C] = (v >= m);
                    r = set_nz(v - m);
                end
                OP_DEC, OP_INC: begin
                    wr_addr[0] = d.target_address;
                    wr_data[0] = set_nz((d.op == OP_DEC) ? m - 8'd1 : m + 8'd1);
                    wr_n = 1;
                end
                OP_DEX: reg_x = set_nz(reg_x - 8'd1);
                OP_DEY: reg_y = set_nz(reg_y - 8'd1);
                OP_EOR: reg_a = set_nz(reg_a ^ m);
                OP_INX: reg_x = set_nz(reg_x + 8'd1);
                OP_INY: reg_y = set_nz(reg_y + 8'd1);
                OP_JMP: reg_pc = d.target_address;
                OP_JSR: begin
                    push_byte(8'((d.next_pc - 16'd1) >> 8));
                    push_byte(8'(d.next_pc - 16'd1));
                    reg_pc = d.target_address;
                end
                OP_LDA: reg_a = set_nz(m);
                OP_LDX: reg_x = set_nz(m);
                OP_LDY: reg_y = set_nz(m);
                OP_NOP: ;
                OP_ORA: reg_a = set_nz(reg_a | m);
                OP_PHA: push_byte(reg_a);
                OP_PHP: push_byte(reg_p | 8'h30);
                OP_PLA: begin
                    reg_sp = reg_sp + 8'd1;
                    reg_a = set_nz(d.pulled_first);
                end
                OP_PLP: begin
                    reg_sp = reg_sp + 8'd1;
                    load_status(d.pulled_first);
                end
                OP_RTI: begin
                    reg_sp = reg_sp + 8'd3;
                    load_status(d.pulled_first);
                    reg_pc = {d.pulled_third, d.pulled_second};
                end
                OP_RTS: begin
                    reg_sp = reg_sp + 8'd2;
                    reg_pc = {d.pulled_second, d.pulled_first} + 16'd1;
                end
                OP_SBC: add_carry(~m);
                OP_SEC: reg_p[FL_C] = 1'b1;
                OP_SED: reg_p[FL_D] = 1'b1;
                OP_SEI: reg_p[FL_I] = 1'b1;
                OP_STA, OP_STX, OP_STY: begin
                    wr_addr[0] = d.target_address;
                    wr_data[0] = (d.op == OP_STA) ? reg_a : (d.op == OP_STX) ? reg_x : reg_y;
                    wr_n = 1;
                end
                OP_TAX: reg_x = set_nz(reg_a);
                OP_TAY: reg_y = set_nz(reg_a);
                OP_TSX: reg_x = set_nz(reg_sp);
                OP_TXA: reg_a = set_nz(reg_x);
                OP_TXS: reg_sp = reg_x;
                OP_TYA: reg_a = set_nz(reg_y);
                OP_WAI: wait_st = 1'b1;
                default: bad_st = 1'b1;
            endcase
            if (take) reg_pc = d.target_address;
        end
        n = (wr_n == 0) ? 1 : wr_n;
        for (int k = 0; k < n; k++) begin
            e.write_en      = (k < wr_n);
            e.write_address = (k < wr_n) ? wr_addr[k] : 16'h0000;
            e.write_data    = (k < wr_n) ? wr_data[k] : 8'h00;
            e.acc_out       = reg_a;
            e.x_out         = reg_x;
            e.y_out         = reg_y;
            e.sp_out        = reg_sp;
            e.status_out    = reg_p;
            e.pc_out        = reg_pc;
            e.invalid_op    = bad_st;
            e.waiting       = wait_st;
            e.last          = (k == n - 1);
            expected_q.push_back(e);
        end
    endtask

    task automatic compare_result(t_out got);
        t_out e;
        if (expected_q.size() == 0) begin
            o_errors++;
            if (o_errors <= 10) $display("unexpected result %h", got);
            return;
        end
        e = expected_q.pop_front();
        if (got !== e) begin
            o_errors++;
            if (o_errors <= 10) $display("mismatch: expected %h actual %h", e, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_a = 8'h00; reg_x = 8'h00; reg_y = 8'h00;
            reg_sp = SP_RESET; reg_p = P_RESET; reg_pc = 16'h0000;
            wait_st = 1'b0; bad_st = 1'b0;
            expected_q.delete();
            o_errors = 0;
        end else begin
            if (i_in.valid && i_in.ready) predict_instr(i_in.data);
            if (i_out.valid && i_out.ready) compare_result(i_out.data);
        end
    end
endmodule

FILE: tb/cpu6502_execute_unit_test.sv
// Testbench top for the execute unit: clock, reset, instruction stimulus and verdict.
// Depends on ceu_pkg, the channel interfaces and cpu6502_execute_unit_checker.
`timescale 1ns / 100ps
module cpu6502_execute_unit_test;
    import ceu_pkg::*;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    logic calm = 1'b0;
    logic hold_off = 1'b0;
    bit   stim_done = 1'b0;

    ceu_in_if  in_ch ();
    ceu_out_if out_ch ();

    cpu6502_execute_unit uut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch));
    cpu6502_execute_unit_checker checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .o_errors(errors), .o_pending(pending));

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    function automatic t_in rand_instr(bit wellformed);
        t_in d;
        d.op = wellformed ? 6'($urandom_range(0, 55)) : 6'($urandom_range(0, 63));
        if (d.op == OP_WAI && $urandom_range(0, 3) != 0) d.op = OP_NOP;
        d.operand        = 8'($urandom);
        d.target_address = 16'($urandom);
        d.acc_mode       = 1'($urandom);
        d.next_pc        = 16'($urandom);
        d.pulled_first   = 8'($urandom);
        d.pulled_second  = 8'($urandom);
        d.pulled_third   = 8'($urandom);
        d.vector         = 16'($urandom);
        if ($urandom_range(0, 9) == 0) d.operand = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return d;
    endfunction

    task automatic send(t_in d);
        while (!calm && $urandom_range(0, 99) < 7) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= d;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_op(t_op op, logic [7:0] m, bit acc);
        t_in d;
        d = rand_instr(1'b1);
        d.op = op;
        d.operand = m;
        d.acc_mode = acc;
        send(d);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) out_ch.ready <= 1'b0;
        else out_ch.ready <= calm || ($urandom_range(0, 99) >= 7);
    end

    initial begin
        t_in d;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_op(OP_LDA, 8'h7F, 1'b0);
        send_op(OP_ADC, 8'h01, 1'b0);
        send_op(OP_SBC, 8'hFF, 1'b0);
        send_op(OP_CMP, 8'h80, 1'b0);
        send_op(OP_ROL, 8'h80, 1'b1);
        send_op(OP_ROR, 8'h01, 1'b0);
        send_op(OP_LSR, 8'hFF, 1'b1);
        send_op(OP_ASL, 8'hFF, 1'b0);
        send_op(OP_BIT, 8'hC0, 1'b0);
        send_op(OP_PHP, 8'h00, 1'b0);
        send_op(OP_PLP, 8'h00, 1'b0);
        send_op(OP_RTI, 8'h00, 1'b0);
        send_op(OP_JSR, 8'h00, 1'b0);
        send_op(OP_RTS, 8'h00, 1'b0);
        send_op(OP_BRK, 8'h00, 1'b0);
        send_op(OP_IRQ, 8'h00, 1'b0);
        send_op(OP_CLI, 8'h00, 1'b0);
        send_op(OP_IRQ, 8'h00, 1'b0);
        send_op(OP_WAI, 8'h00, 1'b0);
        send_op(OP_INX, 8'h00, 1'b0);
        send_op(OP_NMI, 8'h00, 1'b0);
        send_op(OP_SED, 8'h00, 1'b0);
        send_op(OP_TXS, 8'h00, 1'b0);
        d = rand_instr(1'b1);
        d.op = 6'd63;
        send(d);
        for (int i = 0; i < 400; i++) begin
            calm = (i >= 150 && i < 230);
            if (i == 250) hold_off = 1'b1;
            d = rand_instr($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 15) == 0) d.op = ($urandom_range(0, 1) != 0) ? OP_IRQ : OP_NMI;
            send(d);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                repeat (40) @(posedge i_clk);
                hold_off = 1'b0;
            end
        end
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
